[rtl/lctb_pkg.sv]
// Shared types and constants for the least-cost target balancer.
// No dependencies; imported by lctb_argmin and least_cost_target_balancer.
`default_nettype none
package lctb_pkg;

    // Fixed field widths of the item and result ports
    localparam int KIND_W = 3;
    localparam int SESS_IN_W = 8;
    localparam int TGT_IN_W = 4;
    localparam int CAND_W = 16;
    localparam int COST_OUT_W = 18;

    typedef enum logic [KIND_W-1:0] {
        KIND_SELECT = 3'd0,
        KIND_BIND   = 3'd1,
        KIND_REQ    = 3'd2,
        KIND_RSP    = 3'd3,
        KIND_END    = 3'd4
    } t_kind;

    // Control from the sequencer to the running-minimum unit
    typedef struct packed {
        logic clr;
        logic vld;
    } t_am_ctl;

endpackage
`default_nettype wire

[rtl/lctb_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module lctb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/lctb_argmin.sv]
// Running minimum over a stream of (index, cost) pairs; first lowest wins.
// Depends on lctb_pkg.
`default_nettype none
module lctb_argmin
    import lctb_pkg::*;
#(
    parameter int IDX_W = 4,
    parameter int CST_W = 18
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_am_ctl          i_ctl,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire logic [CST_W-1:0] i_cost,
    output logic                  o_found,
    output logic      [IDX_W-1:0] o_idx,
    output logic      [CST_W-1:0] o_cost
);

    logic             r_found;
    logic [IDX_W-1:0] r_idx;
    logic [CST_W-1:0] r_cost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_idx   <= '0;
            r_cost  <= '0;
        end else if (i_ctl.clr) begin
            r_found <= 1'b0;
            r_idx   <= '0;
            r_cost  <= '0;
        end else if (i_ctl.vld && (!r_found || i_cost < r_cost)) begin
            // strict compare keeps the earlier candidate on a tie
            r_found <= 1'b1;
            r_idx   <= i_idx;
            r_cost  <= i_cost;
        end
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;
    assign o_cost  = r_cost;

    a_clr_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clr |=> !r_found)
        else $error("argmin not empty after clear");

    a_found_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && !i_ctl.clr) |=> r_found)
        else $error("argmin lost its candidate");

    a_cost_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && !i_ctl.clr) |=> (r_cost <= $past(r_cost)))
        else $error("argmin cost rose");

endmodule
`default_nettype wire

[rtl/least_cost_target_balancer.sv]
// Top level of the least-cost target balancer: sequencer, session table RAM,
// target stats RAM, present flags. Depends on lctb_pkg, lctb_ram, lctb_argmin.
//
//  channel  | handshake            | signals
//  ---------+----------------------+---------------------------------------------
//  item in  | start & !busy        | i_kind i_session i_target i_candidates
//           |                      | i_front_closed
//  result   | o_done, one cycle    | o_found o_picked o_picked_cost
//
//  Select: the stats RAM is walked one target per cycle through its single read
//  port, over the first min(NUM_TARGETS,16) targets. Other kinds: session read,
//  stats read, then read-modify-write.
//  After reset the session table is cleared, one entry per cycle, with busy high.
//  The result appears as busy falls; it cannot be stalled.
`default_nettype none
module least_cost_target_balancer
    import lctb_pkg::*;
#(
    parameter int NUM_TARGETS  = 16,
    parameter int NUM_SESSIONS = 256,
    parameter int COUNT_BITS   = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [KIND_W-1:0]     i_kind,
    input  wire logic [SESS_IN_W-1:0]  i_session,
    input  wire logic [TGT_IN_W-1:0]   i_target,
    input  wire logic [CAND_W-1:0]     i_candidates,
    input  wire logic                  i_front_closed,
    output logic                       o_done,
    output logic                       o_found,
    output logic [TGT_IN_W-1:0]        o_picked,
    output logic [COST_OUT_W-1:0]      o_picked_cost
);

    localparam int TGT_W = $clog2(NUM_TARGETS);
    localparam int SES_W = $clog2(NUM_SESSIONS);
    localparam int CB    = COUNT_BITS;
    localparam int CST_W = COUNT_BITS + 2;
    localparam int NSCAN = (NUM_TARGETS < CAND_W) ? NUM_TARGETS : CAND_W;
    localparam int SE_W  = TGT_W + 1;
    localparam int ST_W  = 3 * COUNT_BITS;
    localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_DRAIN, S_FIN, S_LOOKUP, S_FETCH, S_APPLY
    } t_state;

    t_state                 r_state;
    logic [SES_W-1:0]       r_clr_addr;
    logic [TGT_W-1:0]       r_idx;
    logic                   r_feed;
    logic [TGT_W-1:0]       r_feed_idx;
    logic [KIND_W-1:0]      r_kind;
    logic [SES_W-1:0]       r_sess;
    logic                   r_sess_ok;
    logic [TGT_W-1:0]       r_tgt;
    logic                   r_tgt_ok;
    logic [CAND_W-1:0]      r_cand;
    logic                   r_front;
    logic                   r_bv;
    logic [TGT_W-1:0]       r_bt;
    logic [NUM_TARGETS-1:0] r_present;
    logic                   r_done;
    logic                   r_found;
    logic [TGT_IN_W-1:0]    r_picked;
    logic [COST_OUT_W-1:0]  r_cost;

    logic                   accept;
    logic [31:0]            sess_ext;
    logic [31:0]            tgt_ext;
    logic                   sess_we;
    logic [SES_W-1:0]       sess_waddr;
    logic [SE_W-1:0]        sess_wdata;
    logic [SE_W-1:0]        sess_app_wdata;
    logic [SE_W-1:0]        sess_rd;
    logic                   sess_app_we;
    logic                   st_we;
    logic [ST_W-1:0]        st_wdata;
    logic [TGT_W-1:0]       st_raddr;
    logic [ST_W-1:0]        st_rd;
    logic [TGT_W-1:0]       at;
    logic                   pres_set;
    logic                   pres_clr;
    logic [CAND_W-1:0]      cand_sh;
    logic [CST_W-1:0]       scan_cost;
    t_am_ctl                am_ctl;
    logic                   am_found;
    logic [TGT_W-1:0]       am_idx;
    logic [CST_W-1:0]       am_cost;
    logic [31:0]            pick_ext;
    logic [63:0]            cost_ext;

    assign accept   = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign sess_ext = 32'(i_session);
    assign tgt_ext  = 32'(i_target);

    // Session table: {valid, target}; cleared by the pass after reset
    assign sess_we    = (r_state == S_CLEAR) || sess_app_we;
    assign sess_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_sess;
    assign sess_wdata = (r_state == S_CLEAR) ? '0 : sess_app_wdata;

    lctb_ram #(.WIDTH(SE_W), .DEPTH(NUM_SESSIONS)) u_sess_ram (
        .i_clk   (i_clk),
        .i_we    (sess_we),
        .i_waddr (sess_waddr),
        .i_wdata (sess_wdata),
        .i_raddr (r_sess),
        .o_rdata (sess_rd)
    );

    // Stats: {deaths, pending, sessions} per target
    assign at       = (r_kind == KIND_BIND) ? r_tgt : r_bt;
    assign st_raddr = (r_state == S_SCAN) ? r_idx :
                      ((r_kind == KIND_BIND) ? r_tgt : sess_rd[TGT_W-1:0]);

    lctb_ram #(.WIDTH(ST_W), .DEPTH(NUM_TARGETS)) u_stat_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (at),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rd)
    );

    // Scan feed: cost of the target read in the previous cycle
    always_comb begin
        logic [CST_W-1:0] sum;
        sum = CST_W'(st_rd[CB-1:0]) + CST_W'(st_rd[2*CB-1:CB])
            + CST_W'(st_rd[3*CB-1:2*CB]);
        cand_sh    = r_cand >> r_feed_idx;
        scan_cost  = r_present[r_feed_idx] ? sum : '0;
        am_ctl.clr = accept && (i_kind == KIND_SELECT);
        am_ctl.vld = r_feed && cand_sh[0];
    end

    lctb_argmin #(.IDX_W(TGT_W), .CST_W(CST_W)) u_argmin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (am_ctl),
        .i_idx   (r_feed_idx),
        .i_cost  (scan_cost),
        .o_found (am_found),
        .o_idx   (am_idx),
        .o_cost  (am_cost)
    );

    assign pick_ext = 32'(am_idx);
    assign cost_ext = 64'(am_cost);

    // Read-modify-write of one event
    always_comb begin
        logic [CB-1:0] sc;
        logic [CB-1:0] pc;
        logic [CB-1:0] dc;
        logic [CB-1:0] sc_n;
        logic [CB-1:0] pc_n;
        logic [CB-1:0] dc_n;
        logic          live;
        sc   = st_rd[CB-1:0];
        pc   = st_rd[2*CB-1:CB];
        dc   = st_rd[3*CB-1:2*CB];
        sc_n = sc;
        pc_n = pc;
        dc_n = dc;
        live = r_sess_ok && r_bv && r_present[r_bt];
        sess_app_we    = 1'b0;
        sess_app_wdata = {1'b1, r_tgt};
        st_we    = 1'b0;
        pres_set = 1'b0;
        pres_clr = 1'b0;
        if (r_state == S_APPLY) begin
            case (r_kind)
                KIND_BIND: begin
                    if (r_sess_ok && r_tgt_ok) begin
                        sess_app_we = !r_bv;
                        st_we       = 1'b1;
                        if (!r_present[r_tgt]) begin
                            pres_set = 1'b1;
                            sc_n     = CB'(1);
                            pc_n     = '0;
                            dc_n     = '0;
                        end else if (sc != CNT_MAX) begin
                            sc_n = sc + CB'(1);
                        end
                    end
                end
                KIND_REQ: begin
                    if (live) begin
                        st_we = 1'b1;
                        if (pc != CNT_MAX) begin
                            pc_n = pc + CB'(1);
                        end
                    end
                end
                KIND_RSP: begin
                    if (live) begin
                        st_we = 1'b1;
                        if (pc != '0) begin
                            pc_n = pc - CB'(1);
                        end
                    end
                end
                KIND_END: begin
                    if (r_sess_ok && r_bv) begin
                        sess_app_we    = 1'b1;
                        sess_app_wdata = {1'b0, r_bt};
                        if (!r_front && live && dc != CNT_MAX) begin
                            dc_n = dc + CB'(1);
                        end
                        if (live) begin
                            st_we = 1'b1;
                            if (sc != '0) begin
                                sc_n = sc - CB'(1);
                            end
                            pres_clr = (sc_n == '0) || (dc_n == '0);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        st_wdata = {dc_n, pc_n, sc_n};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_present  <= '0;
            r_feed     <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_feed <= 1'b0;
            if (pres_set) begin
                r_present[at] <= 1'b1;
            end else if (pres_clr) begin
                r_present[at] <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + SES_W'(1);
                    if (r_clr_addr == SES_W'(NUM_SESSIONS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_kind    <= i_kind;
                        r_sess    <= sess_ext[SES_W-1:0];
                        r_sess_ok <= sess_ext < 32'(NUM_SESSIONS);
                        r_tgt     <= tgt_ext[TGT_W-1:0];
                        r_tgt_ok  <= tgt_ext < 32'(NUM_TARGETS);
                        r_cand    <= i_candidates;
                        r_front   <= i_front_closed;
                        r_idx     <= '0;
                        r_state   <= (i_kind == KIND_SELECT) ? S_SCAN : S_LOOKUP;
                    end
                end
                S_SCAN: begin
                    r_feed     <= 1'b1;
                    r_feed_idx <= r_idx;
                    if (r_idx == TGT_W'(NSCAN - 1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + TGT_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_found  <= am_found;
                    r_picked <= pick_ext[TGT_IN_W-1:0];
                    r_cost   <= cost_ext[COST_OUT_W-1:0];
                    r_done   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_LOOKUP: begin
                    r_state <= S_FETCH;
                end
                S_FETCH: begin
                    r_bv    <= sess_rd[SE_W-1];
                    r_bt    <= sess_rd[TGT_W-1:0];
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_found  <= 1'b0;
                    r_picked <= '0;
                    r_cost   <= '0;
                    r_done   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done        = r_done;
    assign o_found       = r_found;
    assign o_picked      = r_picked;
    assign o_picked_cost = r_cost;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("item accepted but block not busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && !$past(o_done)))
        else $error("result strobe outside a single idle cycle");

    a_found_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found) |-> (r_kind == KIND_SELECT))
        else $error("found set for a non-select item");

endmodule
`default_nettype wire

[tb/tb_least_cost_target_balancer.sv]
// Self-checking testbench for least_cost_target_balancer: directed and random event items,
// with a target-stats predictor and an in-order check of every result strobe.
// Depends on lctb_pkg and the RTL of the block.
`default_nettype none
module tb_least_cost_target_balancer;
    timeunit 1ns;
    timeprecision 1ps;

    import lctb_pkg::*;

    localparam int NUM_TARGETS  = 16;
    localparam int NUM_SESSIONS = 256;
    localparam int COUNT_BITS   = 16;
    localparam int RANDOM_ITEMS = 700;
    localparam int PENDING_REQS = 12;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;
    localparam logic [KIND_W-1:0] KIND_LAST = '1;

    typedef struct packed {
        logic                  found;
        logic [TGT_IN_W-1:0]   picked;
        logic [COST_OUT_W-1:0] cost;
    } t_pick;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [KIND_W-1:0]     i_kind = '0;
    logic [SESS_IN_W-1:0]  i_session = '0;
    logic [TGT_IN_W-1:0]   i_target = '0;
    logic [CAND_W-1:0]     i_candidates = '0;
    logic                  i_front_closed = 1'b0;
    logic                  busy;
    logic                  o_done;
    logic                  o_found;
    logic [TGT_IN_W-1:0]   o_picked;
    logic [COST_OUT_W-1:0] o_picked_cost;

    // Predicted table and per-target stats
    bit                    bound_valid [NUM_SESSIONS];
    logic [TGT_IN_W-1:0]   bound_tgt   [NUM_SESSIONS];
    bit                    present     [NUM_TARGETS];
    logic [COUNT_BITS-1:0] sess_cnt    [NUM_TARGETS];
    logic [COUNT_BITS-1:0] pend_cnt    [NUM_TARGETS];
    logic [COUNT_BITS-1:0] death_cnt   [NUM_TARGETS];

    t_pick pick_queue [$];
    int    gap_max = 5;
    int    mismatch_count = 0;

    least_cost_target_balancer #(
        .NUM_TARGETS  (NUM_TARGETS),
        .NUM_SESSIONS (NUM_SESSIONS),
        .COUNT_BITS   (COUNT_BITS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_session      (i_session),
        .i_target       (i_target),
        .i_candidates   (i_candidates),
        .i_front_closed (i_front_closed),
        .o_done         (o_done),
        .o_found        (o_found),
        .o_picked       (o_picked),
        .o_picked_cost  (o_picked_cost)
    );

    always #4 i_clk = ~i_clk;

    // Applies one event to the predicted stats and returns the pick it yields
    function automatic t_pick balance_event(logic [KIND_W-1:0] kind, logic [SESS_IN_W-1:0] sess,
                                            logic [TGT_IN_W-1:0] tgt, logic [CAND_W-1:0] cand,
                                            logic front);
        t_pick                 pick;
        logic [COST_OUT_W-1:0] cost;
        bit                    is_live;
        logic [TGT_IN_W-1:0]   lt;
        pick    = '0;
        lt      = bound_tgt[sess];
        is_live = bound_valid[sess] && present[lt];
        case (kind)
            KIND_SELECT: begin
                for (int i = 0; i < NUM_TARGETS; i++) begin
                    if (cand[i]) begin
                        cost = '0;
                        if (present[i])
                            cost = COST_OUT_W'(sess_cnt[i]) + COST_OUT_W'(pend_cnt[i])
                                   + COST_OUT_W'(death_cnt[i]);
                        if (!pick.found || cost < pick.cost) begin
                            pick.found  = 1'b1;
                            pick.picked = TGT_IN_W'(i);
                            pick.cost   = cost;
                        end
                    end
                end
            end
            KIND_BIND: begin
                if (!bound_valid[sess]) begin
                    bound_valid[sess] = 1'b1;
                    bound_tgt[sess]   = tgt;
                end
                if (!present[tgt]) begin
                    present[tgt]   = 1'b1;
                    sess_cnt[tgt]  = COUNT_BITS'(1);
                    pend_cnt[tgt]  = '0;
                    death_cnt[tgt] = '0;
                end else if (sess_cnt[tgt] != '1) begin
                    sess_cnt[tgt]++;
                end
            end
            KIND_REQ: begin
                if (is_live && pend_cnt[lt] != '1)
                    pend_cnt[lt]++;
            end
            KIND_RSP: begin
                if (is_live && pend_cnt[lt] != '0)
                    pend_cnt[lt]--;
            end
            KIND_END: begin
                if (bound_valid[sess]) begin
                    if (!front && is_live && death_cnt[lt] != '1)
                        death_cnt[lt]++;
                    bound_valid[sess] = 1'b0;
                    if (is_live) begin
                        if (sess_cnt[lt] != '0)
                            sess_cnt[lt]--;
                        if (sess_cnt[lt] == '0 || death_cnt[lt] == '0)
                            present[lt] = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        return pick;
    endfunction

    // Start stays high across back-to-back items; it only drops for a gap
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SESS_IN_W-1:0] sess,
                             input logic [TGT_IN_W-1:0] tgt, input logic [CAND_W-1:0] cand,
                             input logic front);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_kind         <= kind;
        i_session      <= sess;
        i_target       <= tgt;
        i_candidates   <= cand;
        i_front_closed <= front;
        do @(posedge i_clk); while (busy);
        pick_queue.push_back(balance_event(kind, sess, tgt, cand, front));
    endtask

    task automatic test_empty_table();
        send_item(KIND_SELECT, 8'd0, 4'd0, 16'h0000, 1'b0);
        send_item(KIND_SELECT, 8'd0, 4'd0, 16'hFFFF, 1'b0);
        send_item(KIND_SELECT, 8'd0, 4'd0, 16'h8000, 1'b0);
        for (int k = KIND_END + 1; k <= KIND_LAST; k++)
            send_item(KIND_W'(k), SESS_IN_W'($urandom), TGT_IN_W'($urandom),
                      CAND_W'($urandom), 1'($urandom));
        // events on sessions that were never bound
        send_item(KIND_REQ, 8'd255, 4'd0, 16'h0000, 1'b0);
        send_item(KIND_RSP, 8'd0, 4'd0, 16'h0000, 1'b0);
        send_item(KIND_END, 8'd0, 4'd0, 16'h0000, 1'b0);
    endtask

    task automatic test_bind_and_select();
        send_item(KIND_BIND, 8'd0, 4'd0, 16'h0000, 1'b0);
        send_item(KIND_BIND, 8'd255, 4'd15, 16'h0000, 1'b0);
        // already bound: slot keeps target 0, target 3 still gets a session
        send_item(KIND_BIND, 8'd0, 4'd3, 16'h0000, 1'b0);
        send_item(KIND_SELECT, 8'd0, 4'd0, 16'hFFFF, 1'b0);
        send_item(KIND_SELECT, 8'd0, 4'd0, 16'h8009, 1'b0);
        send_item(KIND_REQ, 8'd0, 4'd0, 16'h0000, 1'b0);
        send_item(KIND_REQ, 8'd0, 4'd0, 16'h0000, 1'b0);
        send_item(KIND_RSP, 8'd255, 4'd0, 16'h0000, 1'b0);
        send_item(KIND_RSP, 8'd255, 4'd0, 16'h0000, 1'b0);
        send_item(KIND_SELECT, 8'd0, 4'd0, 16'h8001, 1'b0);
        send_item(KIND_END, 8'd0, 4'd0, 16'h0000, 1'b0);
        send_item(KIND_BIND, 8'd1, 4'd15, 16'h0000, 1'b0);
        send_item(KIND_BIND, 8'd2, 4'd15, 16'h0000, 1'b0);
        send_item(KIND_END, 8'd1, 4'd0, 16'h0000, 1'b0);
        send_item(KIND_SELECT, 8'd0, 4'd0, 16'h8000, 1'b0);
        send_item(KIND_END, 8'd2, 4'd0, 16'h0000, 1'b1);
        send_item(KIND_END, 8'd255, 4'd0, 16'h0000, 1'b1);
        send_item(KIND_SELECT, 8'd0, 4'd0, 16'h8000, 1'b0);
    endtask

    // Builds up the pending count of one target back to back, then selects on it
    task automatic test_pending_count();
        gap_max = 0;
        send_item(KIND_BIND, 8'd10, 4'd5, 16'h0000, 1'b0);
        send_item(KIND_BIND, 8'd11, 4'd5, 16'h0000, 1'b0);
        send_item(KIND_END, 8'd11, 4'd0, 16'h0000, 1'b0);
        for (int n = 0; n < PENDING_REQS; n++)
            send_item(KIND_REQ, 8'd10, 4'd0, 16'h0000, 1'b0);
        send_item(KIND_SELECT, 8'd0, 4'd0, 16'h0020, 1'b0);
        send_item(KIND_RSP, 8'd10, 4'd0, 16'h0000, 1'b0);
        send_item(KIND_SELECT, 8'd0, 4'd0, 16'hFFE0, 1'b0);
        send_item(KIND_END, 8'd10, 4'd0, 16'h0000, 1'b1);
        gap_max = 5;
    endtask

    task automatic test_random_traffic();
        logic [KIND_W-1:0]    kind;
        logic [SESS_IN_W-1:0] sess;
        logic [TGT_IN_W-1:0]  tgt;
        logic [CAND_W-1:0]    cand;
        int                   roll;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0)
                gap_max = ((n / 100) % 3 == 1) ? 0 : 5;
            // small session pool keeps most events on bound slots
            sess = ($urandom_range(0, 9) == 0) ? SESS_IN_W'($urandom)
                                               : SESS_IN_W'($urandom_range(0, 23));
            tgt  = ($urandom_range(0, 1) == 0) ? TGT_IN_W'($urandom_range(0, 3))
                                               : TGT_IN_W'($urandom);
            case ($urandom_range(0, 9))
                0:       cand = '0;
                1:       cand = '1;
                2:       cand = CAND_W'(1) << $urandom_range(0, CAND_W - 1);
                3, 4:    cand = CAND_W'($urandom) & CAND_W'($urandom);
                default: cand = CAND_W'($urandom) | CAND_W'($urandom);
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 28)
                kind = KIND_BIND;
            else if (roll < 45)
                kind = KIND_REQ;
            else if (roll < 55)
                kind = KIND_RSP;
            else if (roll < 70)
                kind = KIND_END;
            else if (roll < 94)
                kind = KIND_SELECT;
            else
                kind = KIND_W'($urandom_range(KIND_END + 1, KIND_LAST));
            send_item(kind, sess, tgt, cand, 1'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        t_pick exp_pick;
        if (i_rst_n && o_done) begin
            if (pick_queue.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("ERROR: unexpected result found=%0d picked=%0d cost=%0d",
                             o_found, o_picked, o_picked_cost);
                mismatch_count++;
            end else begin
                exp_pick = pick_queue.pop_front();
                if (o_found !== exp_pick.found || o_picked !== exp_pick.picked
                        || o_picked_cost !== exp_pick.cost) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("ERROR: found %0d/%0d picked %0d/%0d cost %0d/%0d (exp/act)",
                                 exp_pick.found, o_found, exp_pick.picked, o_picked,
                                 exp_pick.cost, o_picked_cost);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run when neither an item nor a result moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_done)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        for (int s = 0; s < NUM_SESSIONS; s++) begin
            bound_valid[s] = 1'b0;
            bound_tgt[s]   = '0;
        end
        for (int t = 0; t < NUM_TARGETS; t++) begin
            present[t]   = 1'b0;
            sess_cnt[t]  = '0;
            pend_cnt[t]  = '0;
            death_cnt[t] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_bind_and_select();
        test_pending_count();
        test_random_traffic();

        start <= 1'b0;
        while (pick_queue.size() != 0)
            @(posedge i_clk);
        repeat (25) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
